// ===== rtl/mau_pkg.sv =====
// Package for the modular arithmetic unit: action codes, channel payloads, controller command struct.
// No dependencies.
package mau_pkg;

  localparam int unsigned RawWidth = 64;

  typedef enum logic [2:0] {
    ACT_REDUCE = 3'd0,
    ACT_ADD    = 3'd1,
    ACT_SUB    = 3'd2,
    ACT_MUL    = 3'd3,
    ACT_POW    = 3'd4,
    ACT_INV    = 3'd5,
    ACT_DIV    = 3'd6,
    ACT_NEG    = 3'd7
  } action_e;

  // Request and result payloads
  typedef struct packed {
    action_e              action;
    logic [31:0]          operand_a;
    logic [31:0]          operand_b;
    logic [RawWidth-1:0]  exponent;
    logic [RawWidth-1:0]  raw_value;
  } mau_req_t;

  typedef struct packed {
    logic [31:0] result;
  } mau_res_t;

  // Selects what the shared remainder unit reduces
  typedef enum logic [2:0] {
    SRC_A    = 3'd0,
    SRC_B    = 3'd1,
    SRC_RAW  = 3'd2,
    SRC_AB   = 3'd3,
    SRC_ACC  = 3'd4,
    SRC_SQR  = 3'd5,
    SRC_ONE  = 3'd6
  } src_e;

  // Where a finished remainder is written
  typedef enum logic [2:0] {
    DST_A    = 3'd0,
    DST_B    = 3'd1,
    DST_ACC  = 3'd2,
    DST_BASE = 3'd3,
    DST_RES  = 3'd4
  } dst_e;

  typedef struct packed {
    logic  load;      // capture request fields
    logic  start;     // start a remainder
    src_e  src;
    dst_e  dst;
    logic  base_from_b; // power base taken from b instead of a
    logic  shift_exp; // drop exponent low bit
    logic  finish;    // form result from action
    logic  save_inv;  // keep acc as inverse of b, then reuse for divide
  } mau_cmd_t;

  typedef struct packed {
    logic busy;       // remainder unit running
    logic exp_zero;
    logic exp_lsb;
    logic mod_small;  // modulus below two
  } mau_sts_t;

endpackage

// ===== rtl/mau_if.sv =====
// Valid/ready channel interface carrying a payload of type T.
// Depends on nothing.
interface mau_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/mau_datapath.sv =====
// Datapath: operand registers, a multiplier, and a shift-subtract remainder unit.
// Depends on mau_pkg.
module mau_datapath import mau_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [W-1:0]      modulus_i,
  input  logic [2:0]        action_i,
  input  logic [W-1:0]      a_i,
  input  logic [W-1:0]      b_i,
  input  logic [63:0]       exp_i,
  input  logic [63:0]       raw_i,
  input  mau_cmd_t          cmd_i,
  output mau_sts_t          sts_o,
  output logic [W-1:0]      result_o
);

  localparam int unsigned CntW = 7;

  logic [W-1:0]  a_q, b_q, acc_q, base_q, res_q;
  logic [63:0]   exp_q, raw_q;
  logic          neg_q;
  logic [2:0]    act_q;

  // remainder unit state
  logic [63:0]   dvd_q;
  logic [W:0]    rem_q;
  logic [CntW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  dst_e          dst_q;

  logic [2*W-1:0] prod;
  logic [63:0]   src_val;
  logic [W:0]    rem_sh, rem_nx;
  logic [W-1:0]  rdone;
  logic [W:0]    sum, mb;
  logic [W-1:0]  fin;

  // multiplier feeding the remainder unit
  logic [W-1:0] ma, mbb;
  always_comb begin
    ma = acc_q; mbb = base_q;
    case (cmd_i.src)
      SRC_AB:  begin ma = a_q;    mbb = b_q; end
      SRC_SQR: begin ma = base_q; mbb = base_q; end
      default: begin ma = acc_q;  mbb = base_q; end
    endcase
  end
  assign prod = ma * mbb;

  always_comb begin
    case (cmd_i.src)
      SRC_A:   src_val = 64'(a_q);
      SRC_B:   src_val = 64'(b_q);
      SRC_RAW: src_val = raw_q[63] ? (64'd0 - raw_q) : raw_q;
      SRC_ONE: src_val = 64'd1;
      default: src_val = 64'(prod);
    endcase
  end

  assign rem_sh = {rem_q[W-1:0], dvd_q[63]};
  assign rem_nx = (rem_sh >= {1'b0, modulus_i}) ? rem_sh - {1'b0, modulus_i} : rem_sh;
  assign rdone  = rem_q[W-1:0];

  // final single-step actions
  always_comb begin
    mb  = {1'b0, modulus_i};
    sum = {1'b0, a_q} + {1'b0, b_q};
    fin = res_q;
    case (act_q)
      ACT_ADD: begin
        fin = (sum >= mb) ? W'(sum - mb) : W'(sum);
      end
      ACT_SUB: begin
        sum = {1'b0, a_q} + (mb - {1'b0, b_q});
        fin = (sum >= mb) ? W'(sum - mb) : W'(sum);
      end
      ACT_NEG: fin = (a_q == '0) ? '0 : W'(mb - {1'b0, a_q});
      ACT_REDUCE: fin = (neg_q && res_q != '0) ? modulus_i - res_q : res_q;
      ACT_POW, ACT_INV: fin = acc_q;
      default: fin = res_q;
    endcase
  end

  // remainder unit control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(63)) busy_q <= 1'b0;
    end
  end

  // remainder shift-subtract steps, one dividend bit per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      dvd_q <= src_val;
      rem_q <= '0;
      dst_q <= cmd_i.dst;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[62:0], 1'b0};
      rem_q <= rem_nx;
    end
  end

  // payload registers; a finished remainder is written back the cycle after completion
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q    <= a_i;
      b_q    <= b_i;
      exp_q  <= (action_i == ACT_INV || action_i == ACT_DIV) ?
                (64'(modulus_i) - 64'd2) : exp_i;
      raw_q  <= raw_i;
      neg_q  <= raw_i[63];
      act_q  <= action_i;
      acc_q  <= '0;
      base_q <= '0;
    end else if (done_q) begin
      case (dst_q)
        DST_A:    a_q    <= rdone;
        DST_B:    b_q    <= rdone;
        DST_ACC:  acc_q  <= rdone;
        DST_BASE: base_q <= rdone;
        default:  res_q  <= rdone;
      endcase
    end else begin
      // power base: a for power and inverse, b for divide
      if (cmd_i.start && cmd_i.src == SRC_ONE) base_q <= cmd_i.base_from_b ? b_q : a_q;
      if (cmd_i.shift_exp) exp_q <= {1'b0, exp_q[63:1]};
      // inverse of b replaces b so the final multiply forms a times it
      if (cmd_i.save_inv) b_q <= acc_q;
      if (cmd_i.finish) res_q <= fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= busy_q && (cnt_q == CntW'(63));
  end

  assign sts_o.busy      = busy_q || done_q;
  assign sts_o.exp_zero  = (exp_q == '0);
  assign sts_o.exp_lsb   = exp_q[0];
  assign sts_o.mod_small = (modulus_i < W'(2));
  assign result_o        = res_q;

endmodule

// ===== rtl/mau_ctrl.sv =====
// Controller: sequences the remainder unit through each action.
// Depends on mau_pkg.
module mau_ctrl import mau_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic [2:0] action_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  mau_sts_t  sts_i,
  output mau_cmd_t  cmd_o,
  output logic      zero_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_RA, S_RB, S_WAIT, S_ONE, S_PMUL, S_PSQR, S_PNEXT,
    S_DMUL, S_FIN, S_OUT
  } state_e;

  state_e state_q, ret_q;
  logic [2:0] act_q;
  logic zero_q;

  assign in_ready_o  = (state_q == S_IDLE) || (state_q == S_OUT && out_ready_i);
  assign out_valid_o = (state_q == S_OUT);
  assign zero_o      = zero_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.src = SRC_A;
    cmd_o.dst = DST_A;
    case (state_q)
      S_IDLE, S_OUT: cmd_o.load = in_valid_i && in_ready_o;
      S_RA: begin cmd_o.start = 1'b1; cmd_o.src = SRC_A; cmd_o.dst = DST_A; end
      S_RB: begin
        cmd_o.start = 1'b1;
        if (act_q == ACT_REDUCE) begin cmd_o.src = SRC_RAW; cmd_o.dst = DST_RES; end
        else begin cmd_o.src = SRC_B; cmd_o.dst = DST_B; end
      end
      S_ONE: begin
        cmd_o.start = 1'b1; cmd_o.src = SRC_ONE; cmd_o.dst = DST_ACC;
        cmd_o.base_from_b = (act_q == ACT_DIV);
      end
      S_PMUL: begin
        cmd_o.start = sts_i.exp_lsb; cmd_o.src = SRC_ACC; cmd_o.dst = DST_ACC;
        cmd_o.save_inv = sts_i.exp_zero && (act_q == ACT_DIV);
      end
      S_PSQR: begin cmd_o.start = 1'b1; cmd_o.src = SRC_SQR; cmd_o.dst = DST_BASE; end
      S_PNEXT: cmd_o.shift_exp = 1'b1;
      S_DMUL: begin cmd_o.start = 1'b1; cmd_o.src = SRC_AB; cmd_o.dst = DST_RES; end
      S_FIN: cmd_o.finish = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      act_q   <= ACT_REDUCE;
      zero_q  <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE, S_OUT: begin
          if (state_q == S_OUT && out_ready_i) state_q <= S_IDLE;
          if (in_valid_i && in_ready_o) begin
            act_q  <= action_i;
            zero_q <= sts_i.mod_small;
            state_q <= sts_i.mod_small ? S_FIN : S_RA;
          end
        end
        S_RA: begin state_q <= S_WAIT; ret_q <= S_RB; end
        S_RB: begin
          state_q <= S_WAIT;
          case (act_q)
            ACT_REDUCE, ACT_ADD, ACT_SUB, ACT_NEG: ret_q <= S_FIN;
            ACT_MUL: ret_q <= S_DMUL;
            default: ret_q <= S_ONE;
          endcase
        end
        S_WAIT: if (!sts_i.busy) state_q <= ret_q;
        S_ONE: begin state_q <= S_WAIT; ret_q <= S_PMUL; end
        S_PMUL: begin
          if (sts_i.exp_zero) state_q <= (act_q == ACT_DIV) ? S_DMUL : S_FIN;
          else if (sts_i.exp_lsb) begin state_q <= S_WAIT; ret_q <= S_PSQR; end
          else state_q <= S_PSQR;
        end
        S_PSQR: begin state_q <= S_WAIT; ret_q <= S_PNEXT; end
        S_PNEXT: state_q <= S_PMUL;
        S_DMUL: begin state_q <= S_WAIT; ret_q <= S_FIN; act_q <= ACT_MUL; end
        S_FIN: state_q <= S_OUT;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/modular_arithmetic_unit.sv =====
// Modular arithmetic unit.
// Channels: in_if carries action, operand_a, operand_b, exponent and raw_value;
// out_if carries result. A request is taken when valid and ready are high.
// Configuration: mod_we_i writes mod_wdata_i into the modulus (reset 2).
// Each modular reduction runs on one shared shift-subtract remainder unit.
// Add, subtract, negate and reduce take two reductions, multiply three;
// power, inverse and divide take one squaring per exponent bit and one
// multiply per set bit, with a final multiply for divide.
// One request is in flight at a time; the next is accepted in the cycle its
// result is taken. Reset clears the controller and sets the modulus to 2.
// A stalled receiver holds the result in the output register.
// Depends on mau_pkg, mau_if, mau_ctrl, mau_datapath.
module modular_arithmetic_unit import mau_pkg::*; #(
  parameter int unsigned RESIDUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        mod_we_i,
  input  logic [31:0] mod_wdata_i,
  mau_if.sink         in_if,
  mau_if.source       out_if
);

  localparam int unsigned W = RESIDUE_WIDTH;

  logic [W-1:0] mod_q;
  mau_cmd_t cmd;
  mau_sts_t sts;
  logic zero;
  logic [W-1:0] res;

  // modulus register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       mod_q <= W'(2);
    else if (mod_we_i) mod_q <= mod_wdata_i[W-1:0];
  end

  mau_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .action_i(in_if.data.action),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .sts_i(sts), .cmd_o(cmd), .zero_o(zero)
  );

  mau_datapath #(.W(W)) u_dp (
    .clk_i, .rst_ni,
    .modulus_i(mod_q),
    .action_i(in_if.data.action),
    .a_i(in_if.data.operand_a[W-1:0]),
    .b_i(in_if.data.operand_b[W-1:0]),
    .exp_i(in_if.data.exponent),
    .raw_i(in_if.data.raw_value),
    .cmd_i(cmd), .sts_o(sts), .result_o(res)
  );

  assign out_if.data.result = zero ? 32'd0 : 32'(res);

endmodule

// ===== verif/tb_top.sv =====
// Testbench for modular_arithmetic_unit: random and directed requests over several moduli,
// checked against a built-in residue predictor. Depends on mau_pkg, mau_if and the unit RTL.
module tb_top;
  import mau_pkg::*;

  localparam int unsigned StallLimit = 50000;
  localparam int unsigned MaxReport = 10;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        mod_we_i;
  logic [31:0] mod_wdata_i;

  mau_if #(.T(mau_req_t)) in_if ();
  mau_if #(.T(mau_res_t)) out_if ();

  modular_arithmetic_unit #(.RESIDUE_WIDTH(32)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mod_we_i   (mod_we_i),
    .mod_wdata_i(mod_wdata_i),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  mau_req_t    pending_reqs[$];
  logic [31:0] expected_residues[$];
  logic [31:0] cur_modulus;
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned idle_cycles;
  int unsigned send_gap;
  int unsigned recv_stall;
  bit          steady_mode;
  int unsigned act_count[8];

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Residue predictor
  function automatic logic [63:0] mul_residue(logic [63:0] x, logic [63:0] y,
                                              logic [63:0] m);
    return (x * y) % m;
  endfunction

  function automatic logic [63:0] pow_residue(logic [63:0] base, logic [63:0] e,
                                              logic [63:0] m);
    logic [63:0] acc;
    acc = 64'd1 % m;
    for (int i = 0; i < 64; i++) begin
      if (e[i]) acc = mul_residue(acc, base, m);
      base = mul_residue(base, base, m);
    end
    return acc;
  endfunction

  function automatic logic [31:0] predict_residue(mau_req_t req, logic [31:0] modv);
    logic [63:0] m, a, b, r, mag, s;
    m = {32'd0, modv};
    if (m < 2) return 32'd0;
    a = {32'd0, req.operand_a} % m;
    b = {32'd0, req.operand_b} % m;
    case (req.action)
      ACT_REDUCE: begin
        if (req.raw_value[63]) begin
          mag = (64'd0 - req.raw_value) % m;
          r = (mag == 0) ? 64'd0 : m - mag;
        end else begin
          r = req.raw_value % m;
        end
      end
      ACT_ADD: begin
        s = a + b;
        r = (s >= m) ? s - m : s;
      end
      ACT_SUB: begin
        s = a + (m - b);
        r = (s >= m) ? s - m : s;
      end
      ACT_MUL: r = mul_residue(a, b, m);
      ACT_POW: r = pow_residue(a, req.exponent, m);
      ACT_INV: r = pow_residue(a, m - 2, m);
      ACT_DIV: r = mul_residue(a, pow_residue(b, m - 2, m), m);
      default: r = (a == 0) ? 64'd0 : m - a;
    endcase
    return r[31:0];
  endfunction

  function automatic int unsigned draw_gap();
    int unsigned p;
    if (steady_mode) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
      send_gap    <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_residues.push_back(predict_residue(in_if.data, cur_modulus));
        act_count[in_if.data.action]++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0 && !(in_if.valid && in_if.ready)) begin
          send_gap    <= send_gap - 1;
          in_if.valid <= 1'b0;
        end else if (in_if.valid && in_if.ready && draw_gap() != 0) begin
          send_gap    <= draw_gap();
          in_if.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_if.data  <= pending_reqs.pop_front();
          in_if.valid <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and ready pattern
  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_stall   <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (expected_residues.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReport)
            $display("unexpected result %h", out_if.data.result);
        end else begin
          want = expected_residues.pop_front();
          if (out_if.data.result !== want) begin
            mismatches++;
            if (mismatches <= MaxReport)
              $display("result mismatch: expected %h got %h (modulus %h)",
                       want, out_if.data.result, cur_modulus);
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall   <= recv_stall - 1;
        out_if.ready <= 1'b0;
      end else begin
        recv_stall   <= draw_gap();
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no accepted request or result
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic mau_req_t rand_req(action_e act, logic [31:0] modv);
    mau_req_t r;
    r.action    = act;
    r.operand_a = $urandom;
    r.operand_b = $urandom;
    if (modv > 1 && $urandom_range(0, 3) != 0) begin
      r.operand_a = r.operand_a % modv;
      r.operand_b = r.operand_b % modv;
    end
    r.exponent  = ($urandom_range(0, 9) < 7) ? 64'($urandom_range(0, 40))
                                             : {$urandom, $urandom};
    r.raw_value = {$urandom, $urandom};
    return r;
  endfunction

  function automatic mau_req_t mk_req(action_e act, logic [31:0] a, logic [31:0] b,
                                      logic [63:0] e, logic [63:0] raw);
    mau_req_t r;
    r.action    = act;
    r.operand_a = a;
    r.operand_b = b;
    r.exponent  = e;
    r.raw_value = raw;
    return r;
  endfunction

  task automatic drain_unit();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || in_if.valid || expected_residues.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_modulus(logic [31:0] v);
    @(posedge clk_i);
    mod_we_i    <= 1'b1;
    mod_wdata_i <= v;
    cur_modulus <= v;
    @(posedge clk_i);
    mod_we_i    <= 1'b0;
  endtask

  task automatic run_random(int unsigned n);
    for (int i = 0; i < n; i++)
      pending_reqs.push_back(rand_req(action_e'($urandom_range(0, 7)), cur_modulus));
  endtask

  // Stimulus phases
  initial begin
    logic [31:0] phase_mods[6];
    phase_mods = '{32'd0, 32'd1, 32'd7, 32'hFFFF_FFFF, 32'd1000003, 32'h8000_000B};
    rst_ni      = 1'b0;
    mod_we_i    = 1'b0;
    mod_wdata_i = '0;
    cur_modulus = 32'd2;
    steady_mode = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset modulus 2: every action once
    for (int k = 0; k < 8; k++)
      pending_reqs.push_back(rand_req(action_e'(k), cur_modulus));
    drain_unit();

    // Directed corners on the largest 32-bit prime
    write_modulus(32'hFFFF_FFFB);
    pending_reqs.push_back(mk_req(ACT_REDUCE, 0, 0, 0, 64'h8000_0000_0000_0000));
    pending_reqs.push_back(mk_req(ACT_REDUCE, 0, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF));
    pending_reqs.push_back(mk_req(ACT_REDUCE, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF));
    pending_reqs.push_back(mk_req(ACT_REDUCE, 0, 0, 0, -64'sd4294967291));
    pending_reqs.push_back(mk_req(ACT_ADD, 32'hFFFF_FFFA, 32'hFFFF_FFFA, 0, 0));
    pending_reqs.push_back(mk_req(ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0));
    pending_reqs.push_back(mk_req(ACT_SUB, 0, 32'hFFFF_FFFA, 0, 0));
    pending_reqs.push_back(mk_req(ACT_SUB, 32'd5, 0, 0, 0));
    pending_reqs.push_back(mk_req(ACT_MUL, 32'hFFFF_FFFA, 32'hFFFF_FFFA, 0, 0));
    pending_reqs.push_back(mk_req(ACT_POW, 32'd3, 0, 64'd0, 0));
    pending_reqs.push_back(mk_req(ACT_POW, 32'hFFFF_FFFA, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0));
    pending_reqs.push_back(mk_req(ACT_POW, 0, 0, 64'd0, 0));
    pending_reqs.push_back(mk_req(ACT_INV, 32'd2, 0, 0, 0));
    pending_reqs.push_back(mk_req(ACT_INV, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(ACT_DIV, 32'd1, 32'hFFFF_FFFA, 0, 0));
    pending_reqs.push_back(mk_req(ACT_DIV, 32'd9, 0, 0, 0));
    pending_reqs.push_back(mk_req(ACT_NEG, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(ACT_NEG, 32'hFFFF_FFFF, 0, 0, 0));
    drain_unit();

    // Random phases; odd ones run without idling
    foreach (phase_mods[p]) begin
      write_modulus(phase_mods[p]);
      steady_mode = p[0];
      run_random((phase_mods[p] < 2) ? 6 : 16);
      drain_unit();
    end
    write_modulus($urandom | 32'd2);
    steady_mode = 1'b0;
    run_random(12);
    drain_unit();

    $display("covered %0d results: reduce %0d add %0d sub %0d mul %0d pow %0d",
             results_seen, act_count[0], act_count[1], act_count[2], act_count[3],
             act_count[4]);
    $display("inverse %0d divide %0d negate %0d over 9 moduli incl 0, 1 and 2^32-1",
             act_count[5], act_count[6], act_count[7]);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mau_pkg.sv
rtl/mau_if.sv
rtl/mau_datapath.sv
rtl/mau_ctrl.sv
rtl/modular_arithmetic_unit.sv
verif/tb_top.sv
